@@ hw/rtl/spi_mb_pkg.sv @@
`default_nettype none

package spi_mb_pkg;

  localparam int unsigned BitsPerWord = 8;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned ModeW       = 2;
  localparam int unsigned TicksW      = 16;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_SELECT   = 2'd1,
    KIND_DESELECT = 2'd2,
    KIND_SWAP     = 2'd3
  } kind_t;

  localparam logic [CfgIndexW-1:0] REG_CLK_MODE   = CfgIndexW'(0);
  localparam logic [CfgIndexW-1:0] REG_SLOT_TICKS = CfgIndexW'(1);

  // one queued transaction, already classified
  typedef struct packed {
    kind_t             kind;
    logic [ByteW-1:0]  tx_byte;
    logic              miso;
  } item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

`default_nettype wire

@@ hw/rtl/spi_master_byte_shifter_core.sv @@
`default_nettype none
// Path: a transaction waits in the input queue, and its result is then held
//   and shown in the output register.
// Throughput: one transaction per cycle while the queue holds one and the
//   output is not stalled; a two-entry queue lets input and output stall apart.
// Reset (rst, synchronous): queue empty, spi_mode 0, slot_ticks 1, CS level
//   high, SCK level low, no swap active, no result pending (pins not reset).
module spi_master_byte_shifter_core #(
  parameter int unsigned BITS_PER_WORD = spi_mb_pkg::BitsPerWord
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [spi_mb_pkg::CfgIndexW-1:0]  cfg_index,
  input  wire logic [spi_mb_pkg::TicksW-1:0]     cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        kind,
  input  wire logic [spi_mb_pkg::ByteW-1:0]      tx_byte,
  input  wire logic                              miso,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   cs_n,
  output logic                                   sck,
  output logic                                   mosi,
  output logic                                   busy_res,
  output logic [spi_mb_pkg::ByteW-1:0]           rx_byte,
  output logic                                   rx_done
);
  import spi_mb_pkg::*;

  head_t head;
  logic  pop;

  spi_mb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .tx_byte  (tx_byte),
    .miso     (miso),
    .head     (head),
    .pop      (pop)
  );

  spi_mb_back #(
    .BITS_PER_WORD (BITS_PER_WORD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cs_n      (cs_n),
    .sck       (sck),
    .mosi      (mosi),
    .busy_res  (busy_res),
    .rx_byte   (rx_byte),
    .rx_done   (rx_done)
  );

endmodule

`default_nettype wire

@@ hw/rtl/spi_mb_front.sv @@
`default_nettype none

module spi_mb_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    kind,
  input  wire logic [spi_mb_pkg::ByteW-1:0]  tx_byte,
  input  wire logic                          miso,
  output spi_mb_pkg::head_t                  head,
  input  wire logic                          pop
);
  import spi_mb_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t           entries [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  item_t           in_item;

  always_comb begin
    unique case (kind)
      2'd0:    in_item.kind = KIND_TICK;
      2'd1:    in_item.kind = KIND_SELECT;
      2'd2:    in_item.kind = KIND_DESELECT;
      default: in_item.kind = KIND_SWAP;
    endcase
    in_item.tx_byte = tx_byte;
    in_item.miso    = miso;
  end

  assign in_stall   = (count == CntW'(QueueDepth));
  assign push       = in_valid && !in_stall;
  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/spi_mb_back.sv @@
`default_nettype none

module spi_mb_back #(
  parameter int unsigned BITS_PER_WORD = spi_mb_pkg::BitsPerWord
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [spi_mb_pkg::CfgIndexW-1:0]   cfg_index,
  input  wire logic [spi_mb_pkg::TicksW-1:0]      cfg_data,
  input  wire spi_mb_pkg::head_t                  head,
  output logic                                    pop,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    cs_n,
  output logic                                    sck,
  output logic                                    mosi,
  output logic                                    busy_res,
  output logic [spi_mb_pkg::ByteW-1:0]            rx_byte,
  output logic                                    rx_done
);
  import spi_mb_pkg::*;

  localparam int unsigned W    = BITS_PER_WORD;
  localparam int unsigned CntW = $clog2(BITS_PER_WORD + 1);

  logic [ModeW-1:0]  clk_mode, clk_mode_next;
  logic [TicksW-1:0] slot_ticks, slot_ticks_next;
  logic              cs_level, cs_level_next;
  logic              sck_level, sck_level_next;
  logic              mosi_level, mosi_level_next;
  logic [W-1:0]      tx_shift, tx_shift_next;
  logic [W-1:0]      rx_shift, rx_shift_next;
  logic [CntW-1:0]   bit_count, bit_count_next;
  logic [1:0]        slot_phase, slot_phase_next;
  logic [TicksW-1:0] slot_timer, slot_timer_next;
  logic              active, active_next;
  logic              done;

  logic [TicksW:0]   timer_inc;
  logic [TicksW:0]   limit;
  logic              cpol;
  logic              cpha;
  logic [W-1:0]      tx_load;
  logic [ByteW-1:0]  rx_low;

  generate
    if (W >= ByteW) begin : g_wide
      assign tx_load = W'(head.item.tx_byte);
      assign rx_low  = rx_shift_next[ByteW-1:0];
    end else begin : g_narrow
      assign tx_load = head.item.tx_byte[W-1:0];
      assign rx_low  = ByteW'(rx_shift_next);
    end
  endgenerate

  assign pop       = head.valid && (!out_valid || !out_stall);
  assign cpol      = clk_mode[1];
  assign cpha      = clk_mode[0];
  assign timer_inc = {1'b0, slot_timer} + (TicksW + 1)'(1);
  assign limit     = (slot_ticks == '0) ? (TicksW + 1)'(1) : {1'b0, slot_ticks};

  always_comb begin
    clk_mode_next   = clk_mode;
    slot_ticks_next = slot_ticks;
    cs_level_next   = cs_level;
    sck_level_next  = sck_level;
    mosi_level_next = mosi_level;
    tx_shift_next   = tx_shift;
    rx_shift_next   = rx_shift;
    bit_count_next  = bit_count;
    slot_phase_next = slot_phase;
    slot_timer_next = slot_timer;
    active_next     = active;
    done            = 1'b0;

    if (cfg_we) begin
      if (cfg_index == REG_CLK_MODE) begin
        clk_mode_next  = cfg_data[ModeW-1:0];
        cs_level_next  = 1'b1;
        sck_level_next = cfg_data[1];
        active_next    = 1'b0;
      end else if (cfg_index == REG_SLOT_TICKS) begin
        slot_ticks_next = cfg_data;
      end
    end else if (pop) begin
      if (active) begin
        if (head.item.kind == KIND_TICK) begin
          if (timer_inc >= limit) begin
            slot_timer_next = '0;
            slot_phase_next = slot_phase + 2'd1;
            // slot 3 always closes the bit, whichever phase
            case (slot_phase)
              2'd0: begin
                if (cpha) sck_level_next  = ~cpol;
                else      mosi_level_next = tx_shift[W-1];
              end
              2'd1: begin
                if (cpha) mosi_level_next = tx_shift[W-1];
                else      sck_level_next  = ~cpol;
              end
              2'd2: begin
                if (cpha) sck_level_next = cpol;
                else      rx_shift_next  = (rx_shift << 1) | W'(head.item.miso);
              end
              default: begin
                if (cpha) rx_shift_next  = (rx_shift << 1) | W'(head.item.miso);
                else      sck_level_next = cpol;
                tx_shift_next  = tx_shift << 1;
                bit_count_next = bit_count + CntW'(1);
                if (bit_count == CntW'(W - 1)) begin
                  active_next = 1'b0;
                  done        = 1'b1;
                end
              end
            endcase
          end else begin
            slot_timer_next = timer_inc[TicksW-1:0];
          end
        end
      end else begin
        unique case (head.item.kind)
          KIND_SELECT:   cs_level_next = 1'b0;
          KIND_DESELECT: cs_level_next = 1'b1;
          KIND_SWAP: begin
            tx_shift_next   = tx_load;
            rx_shift_next   = '0;
            bit_count_next  = '0;
            slot_phase_next = '0;
            slot_timer_next = '0;
            sck_level_next  = cpol;
            active_next     = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_mode   <= '0;
      slot_ticks <= TicksW'(1);
      cs_level   <= 1'b1;
      sck_level  <= 1'b0;
      mosi_level <= 1'b0;
      tx_shift   <= '0;
      rx_shift   <= '0;
      bit_count  <= '0;
      slot_phase <= '0;
      slot_timer <= '0;
      active     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      clk_mode   <= clk_mode_next;
      slot_ticks <= slot_ticks_next;
      cs_level   <= cs_level_next;
      sck_level  <= sck_level_next;
      mosi_level <= mosi_level_next;
      tx_shift   <= tx_shift_next;
      rx_shift   <= rx_shift_next;
      bit_count  <= bit_count_next;
      slot_phase <= slot_phase_next;
      slot_timer <= slot_timer_next;
      active     <= active_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the result while the consumer stalls
  always_ff @(posedge clk) begin
    if (pop) begin
      cs_n     <= cs_level_next;
      sck      <= sck_level_next;
      mosi     <= mosi_level_next;
      busy_res <= active_next;
      rx_byte  <= done ? rx_low : '0;
      rx_done  <= done;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/spi_mb_checker.sv @@
`default_nettype none

module spi_mb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       busy_res,
  input wire logic [7:0] rx_byte,
  input wire logic       rx_done
);

  // a completed swap is never reported as still busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_done |-> !busy_res)
    else $error("rx_done shown while busy");

  // received byte reads zero unless the swap completes
  a_rx_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rx_done |-> rx_byte == 8'd0)
    else $error("rx_byte nonzero without rx_done");

  // reset leaves queue and output register empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rx_done) && $stable(rx_byte))
    else $error("stalled result changed");

endmodule

bind spi_master_byte_shifter_core spi_mb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .busy_res  (busy_res),
  .rx_byte   (rx_byte),
  .rx_done   (rx_done)
);

`default_nettype wire
